/* sv/qrs_pkg.sv */
// ----------------------------------------------------------------------------
// qrs_pkg: shared types and constants for the quadratic root solver
// Widths of the fixed-point datapath, root class codes and sideband structs.
// ----------------------------------------------------------------------------
package qrs_pkg;

    localparam int COEF_W    = 16;
    localparam int DISC_W    = 34;
    localparam int MAG_W     = 34;
    localparam int RAD_SHIFT = 30;
    localparam int ROOT_W    = 32;
    localparam int QUO_W     = 34;
    localparam int DIVR_W    = 16;
    localparam int NB_W      = 32;

    localparam logic [1:0] KIND_TWO_REAL = 2'd0;
    localparam logic [1:0] KIND_REPEATED = 2'd1;
    localparam logic [1:0] KIND_COMPLEX  = 2'd2;
    localparam logic [1:0] KIND_A_ZERO   = 2'd3;

    typedef struct packed {
        logic [1:0]               kind;
        logic signed [DISC_W-1:0] disc;
        logic signed [NB_W-1:0]   nb;
        logic                     a_neg;
        logic [DIVR_W-1:0]        a_mag;
    } front_t;

    typedef struct packed {
        logic                     neg;
        logic [1:0]               kind;
        logic signed [DISC_W-1:0] disc;
    } res_t;

endpackage

/* sv/qrs_front.sv */
// ----------------------------------------------------------------------------
// qrs_front: discriminant front end
// Three stages: input capture, products b*b and a*c, discriminant and class.
// ----------------------------------------------------------------------------
module qrs_front (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            en,
    input  logic                            in_valid,
    input  logic signed [qrs_pkg::COEF_W-1:0] coef_a,
    input  logic signed [qrs_pkg::COEF_W-1:0] coef_b,
    input  logic signed [qrs_pkg::COEF_W-1:0] coef_c,
    output logic                            out_valid,
    output logic [qrs_pkg::MAG_W-1:0]       out_mag,
    output qrs_pkg::front_t                 out_info
);
    import qrs_pkg::*;

    logic                     v1_reg, v2_reg, v3_reg;
    logic signed [COEF_W-1:0] a1_reg, b1_reg, c1_reg;
    logic signed [COEF_W-1:0] a2_reg, b2_reg;
    logic signed [31:0]       bb2_reg, ac2_reg;
    logic [MAG_W-1:0]         mag3_reg;
    front_t                   info3_reg;

    logic signed [DISC_W-1:0] disc_next;
    logic [MAG_W-1:0]         mag_next;
    front_t                   info_next;

    always_comb begin
        disc_next = {{2{bb2_reg[31]}}, bb2_reg} - {ac2_reg, 2'b00};
        mag_next  = disc_next[DISC_W-1] ? MAG_W'(-disc_next) : MAG_W'(disc_next);
        info_next.disc  = disc_next;
        info_next.nb    = NB_W'(0) - {b2_reg[COEF_W-1], b2_reg, 15'b0};
        info_next.a_neg = a2_reg[COEF_W-1];
        info_next.a_mag = a2_reg[COEF_W-1] ? DIVR_W'(-a2_reg) : DIVR_W'(a2_reg);
        if (a2_reg == '0) begin
            info_next.kind = KIND_A_ZERO;
        end else if (disc_next > 0) begin
            info_next.kind = KIND_TWO_REAL;
        end else if (disc_next == 0) begin
            info_next.kind = KIND_REPEATED;
        end else begin
            info_next.kind = KIND_COMPLEX;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a1_reg    <= coef_a;
            b1_reg    <= coef_b;
            c1_reg    <= coef_c;
            a2_reg    <= a1_reg;
            b2_reg    <= b1_reg;
            bb2_reg   <= b1_reg * b1_reg;
            ac2_reg   <= a1_reg * c1_reg;
            mag3_reg  <= mag_next;
            info3_reg <= info_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_mag   = mag3_reg;
    assign out_info  = info3_reg;

endmodule

/* sv/qrs_sqrt.sv */
// ----------------------------------------------------------------------------
// qrs_sqrt: pipelined integer square root
// floor(sqrt(mag * 2^30)), one result bit per stage, sideband tag alongside.
// ----------------------------------------------------------------------------
module qrs_sqrt #(
    parameter int TAG_W = 8
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [qrs_pkg::MAG_W-1:0]   in_mag,
    input  logic [TAG_W-1:0]            in_tag,
    output logic                        out_valid,
    output logic [qrs_pkg::ROOT_W-1:0]  out_root,
    output logic [TAG_W-1:0]            out_tag
);
    import qrs_pkg::*;

    localparam int N = ROOT_W;

    logic              vld_reg  [N];
    logic [MAG_W-1:0]  mag_reg  [N];
    logic [ROOT_W:0]   rem_reg  [N];
    logic [ROOT_W-1:0] root_reg [N];
    logic [TAG_W-1:0]  tag_reg  [N];

    for (genvar k = 0; k < N; k++) begin : g_stage
        logic                      cur_v;
        logic [MAG_W-1:0]          cur_mag;
        logic [ROOT_W:0]           cur_rem;
        logic [ROOT_W-1:0]         cur_root;
        logic [TAG_W-1:0]          cur_tag;
        logic [MAG_W+RAD_SHIFT-1:0] rad;
        logic [1:0]                pair;
        logic [ROOT_W+3:0]         trial;

        if (k == 0) begin : g_first
            assign cur_v    = in_valid;
            assign cur_mag  = in_mag;
            assign cur_rem  = '0;
            assign cur_root = '0;
            assign cur_tag  = in_tag;
        end else begin : g_next
            assign cur_v    = vld_reg[k-1];
            assign cur_mag  = mag_reg[k-1];
            assign cur_rem  = rem_reg[k-1];
            assign cur_root = root_reg[k-1];
            assign cur_tag  = tag_reg[k-1];
        end

        assign rad   = {cur_mag, {RAD_SHIFT{1'b0}}};
        assign pair  = rad[2*ROOT_W-1-2*k -: 2];
        assign trial = {1'b0, cur_rem, pair} - {2'b00, cur_root, 2'b01};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= cur_v;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                mag_reg[k] <= cur_mag;
                tag_reg[k] <= cur_tag;
                if (!trial[ROOT_W+3]) begin
                    rem_reg[k]  <= trial[ROOT_W:0];
                    root_reg[k] <= {cur_root[ROOT_W-2:0], 1'b1};
                end else begin
                    rem_reg[k]  <= {cur_rem[ROOT_W-2:0], pair};
                    root_reg[k] <= {cur_root[ROOT_W-2:0], 1'b0};
                end
            end
        end
    end

    assign out_valid = vld_reg[N-1];
    assign out_root  = root_reg[N-1];
    assign out_tag   = tag_reg[N-1];

endmodule

/* sv/qrs_div.sv */
// ----------------------------------------------------------------------------
// qrs_div: pipelined unsigned divider
// Restoring division, one quotient bit per stage, sideband tag alongside.
// ----------------------------------------------------------------------------
module qrs_div #(
    parameter int TAG_W = 1
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [qrs_pkg::QUO_W-1:0]   in_dvd,
    input  logic [qrs_pkg::DIVR_W-1:0]  in_dvr,
    input  logic [TAG_W-1:0]            in_tag,
    output logic                        out_valid,
    output logic [qrs_pkg::QUO_W-1:0]   out_quo,
    output logic [TAG_W-1:0]            out_tag
);
    import qrs_pkg::*;

    localparam int N = QUO_W;

    logic              vld_reg [N];
    logic [QUO_W-1:0]  dvd_reg [N];
    logic [DIVR_W-1:0] dvr_reg [N];
    logic [DIVR_W-1:0] rem_reg [N];
    logic [QUO_W-1:0]  quo_reg [N];
    logic [TAG_W-1:0]  tag_reg [N];

    for (genvar k = 0; k < N; k++) begin : g_stage
        logic              cur_v;
        logic [QUO_W-1:0]  cur_dvd;
        logic [DIVR_W-1:0] cur_dvr;
        logic [DIVR_W-1:0] cur_rem;
        logic [QUO_W-1:0]  cur_quo;
        logic [TAG_W-1:0]  cur_tag;
        logic [DIVR_W:0]   part;
        logic [DIVR_W+1:0] diff;

        if (k == 0) begin : g_first
            assign cur_v   = in_valid;
            assign cur_dvd = in_dvd;
            assign cur_dvr = in_dvr;
            assign cur_rem = '0;
            assign cur_quo = '0;
            assign cur_tag = in_tag;
        end else begin : g_next
            assign cur_v   = vld_reg[k-1];
            assign cur_dvd = dvd_reg[k-1];
            assign cur_dvr = dvr_reg[k-1];
            assign cur_rem = rem_reg[k-1];
            assign cur_quo = quo_reg[k-1];
            assign cur_tag = tag_reg[k-1];
        end

        assign part = {cur_rem, cur_dvd[QUO_W-1-k]};
        assign diff = {1'b0, part} - {2'b00, cur_dvr};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= cur_v;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                dvd_reg[k] <= cur_dvd;
                dvr_reg[k] <= cur_dvr;
                tag_reg[k] <= cur_tag;
                if (!diff[DIVR_W+1]) begin
                    rem_reg[k] <= diff[DIVR_W-1:0];
                    quo_reg[k] <= {cur_quo[QUO_W-2:0], 1'b1};
                end else begin
                    rem_reg[k] <= part[DIVR_W-1:0];
                    quo_reg[k] <= {cur_quo[QUO_W-2:0], 1'b0};
                end
            end
        end
    end

    assign out_valid = vld_reg[N-1];
    assign out_quo   = quo_reg[N-1];
    assign out_tag   = tag_reg[N-1];

endmodule

/* sv/quadratic_root_solver_top.sv */
// ----------------------------------------------------------------------------
// quadratic_root_solver_top: fixed-point quadratic root solver
// Q8.8 coefficients in; root class, two Q16.16 roots, discriminant out.
//
//  Channel   Direction  Payload
//  s_axis    in         tdata: coef_a, coef_b, coef_c
//  m_axis    out        tuser: root_kind; tdata: roots, discriminant, clipped
//
// The pipeline holds 3 front-end stages, 32 square-root stages, one
// numerator stage, 34 divider stages and the output register.
// One transaction per cycle is accepted in steady state while m_axis is not stalled.
// Reset clears every valid bit; payload registers are not reset.
// A stalled output freezes the whole pipeline; s_axis_tready drops with it.
// ----------------------------------------------------------------------------
module quadratic_root_solver_top (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [47:0]  s_axis_tdata,  // coef_a[15:0], coef_b[31:16], coef_c[47:32]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [103:0] m_axis_tdata,  // root_one[31:0], root_two[63:32],
                                        // disc_value[97:64], clipped[98], zero pad
    output logic [1:0]   m_axis_tuser   // root_kind[1:0]
);
    import qrs_pkg::*;

    logic en;

    logic             f_valid;
    logic [MAG_W-1:0] f_mag;
    front_t           f_info;

    logic              q_valid;
    logic [ROOT_W-1:0] q_root;
    logic [$bits(front_t)-1:0] q_tag;
    front_t            q_info;

    logic              n_valid_reg;
    logic [QUO_W-1:0]  un1_reg, un2_reg;
    logic [DIVR_W-1:0] dvr_reg;
    res_t              t1_reg;
    logic              neg2_reg;

    logic signed [QUO_W-1:0] nb_ext, s_ext, n1, n2;
    logic [QUO_W-1:0]        m1, m2;
    res_t                    t1_next;

    logic                       d1_valid, d2_valid;
    logic [QUO_W-1:0]           quo1, quo2;
    logic [$bits(res_t)-1:0]    d1_tag;
    logic                       d2_tag;
    res_t                       r_info;
    logic [32:0]                sat1, sat2;

    logic              m_valid_reg;
    logic [1:0]        m_kind_reg;
    logic [ROOT_W-1:0] m_one_reg, m_two_reg;
    logic [DISC_W-1:0] m_disc_reg;
    logic              m_clip_reg;

    logic [ROOT_W-1:0] one_next, two_next;
    logic              clip_next;

    function automatic logic [32:0] sat_root(input logic neg, input logic [QUO_W-1:0] q);
        if (neg) begin
            if (q > QUO_W'(34'h080000000)) begin
                return {1'b1, 32'h80000000};
            end
            return {1'b0, ROOT_W'(QUO_W'(0) - q)};
        end
        if (q > QUO_W'(34'h07FFFFFFF)) begin
            return {1'b1, 32'h7FFFFFFF};
        end
        return {1'b0, q[ROOT_W-1:0]};
    endfunction

    assign en            = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = en;

    qrs_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_axis_tvalid),
        .coef_a    (s_axis_tdata[15:0]),
        .coef_b    (s_axis_tdata[31:16]),
        .coef_c    (s_axis_tdata[47:32]),
        .out_valid (f_valid),
        .out_mag   (f_mag),
        .out_info  (f_info)
    );

    qrs_sqrt #(.TAG_W($bits(front_t))) u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (f_valid),
        .in_mag    (f_mag),
        .in_tag    (f_info),
        .out_valid (q_valid),
        .out_root  (q_root),
        .out_tag   (q_tag)
    );

    assign q_info = front_t'(q_tag);

    // numerators: -b*2^15 +/- S, or S alone for the imaginary part
    always_comb begin
        nb_ext = {{(QUO_W-NB_W){q_info.nb[NB_W-1]}}, q_info.nb};
        s_ext  = {{(QUO_W-ROOT_W){1'b0}}, q_root};
        if (q_info.kind == KIND_COMPLEX) begin
            n1 = nb_ext;
            n2 = s_ext;
        end else begin
            n1 = nb_ext + s_ext;
            n2 = nb_ext - s_ext;
        end
        m1 = (n1[QUO_W-1] ? QUO_W'(-n1) : QUO_W'(n1))
             + QUO_W'(q_info.a_mag[DIVR_W-1:1]);
        m2 = (n2[QUO_W-1] ? QUO_W'(-n2) : QUO_W'(n2))
             + QUO_W'(q_info.a_mag[DIVR_W-1:1]);
        t1_next.neg  = n1[QUO_W-1] ^ q_info.a_neg;
        t1_next.kind = q_info.kind;
        t1_next.disc = q_info.disc;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_valid_reg <= 1'b0;
        end else if (en) begin
            n_valid_reg <= q_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            un1_reg  <= m1;
            un2_reg  <= m2;
            dvr_reg  <= q_info.a_mag;
            t1_reg   <= t1_next;
            neg2_reg <= n2[QUO_W-1] ^ q_info.a_neg;
        end
    end

    qrs_div #(.TAG_W($bits(res_t))) u_div_one (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (n_valid_reg),
        .in_dvd    (un1_reg),
        .in_dvr    (dvr_reg),
        .in_tag    (t1_reg),
        .out_valid (d1_valid),
        .out_quo   (quo1),
        .out_tag   (d1_tag)
    );

    qrs_div #(.TAG_W(1)) u_div_two (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (n_valid_reg),
        .in_dvd    (un2_reg),
        .in_dvr    (dvr_reg),
        .in_tag    (neg2_reg),
        .out_valid (d2_valid),
        .out_quo   (quo2),
        .out_tag   (d2_tag)
    );

    assign r_info = res_t'(d1_tag);

    always_comb begin
        sat1 = sat_root(r_info.neg, quo1);
        sat2 = sat_root(d2_tag, quo2);
        if (r_info.kind == KIND_A_ZERO) begin
            one_next  = '0;
            two_next  = '0;
            clip_next = 1'b0;
        end else begin
            one_next  = sat1[ROOT_W-1:0];
            two_next  = sat2[ROOT_W-1:0];
            clip_next = sat1[32] | sat2[32];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= d1_valid & d2_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_kind_reg <= r_info.kind;
            m_one_reg  <= one_next;
            m_two_reg  <= two_next;
            m_disc_reg <= r_info.disc;
            m_clip_reg <= clip_next;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_kind_reg;
    assign m_axis_tdata  = {5'b0, m_clip_reg, m_disc_reg, m_two_reg, m_one_reg};

endmodule

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// tb: self-checking testbench for quadratic_root_solver_top
// Drives Q8.8 coefficient sets into s_axis, predicts each result in fixed
// point and compares root class, roots, discriminant and clip flag on m_axis.
// ----------------------------------------------------------------------------
module tb;
    import qrs_pkg::*;

    typedef struct packed {
        logic [1:0]               kind;
        logic signed [ROOT_W-1:0] r1;
        logic signed [ROOT_W-1:0] r2;
        logic signed [DISC_W-1:0] disc;
        logic                     clip;
    } roots_t;

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         s_axis_tvalid = 0;
    logic         s_axis_tready;
    logic [47:0]  s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 0;
    logic [103:0] m_axis_tdata;
    logic [1:0]   m_axis_tuser;

    roots_t expected_roots[$];
    int     n_errors = 0;
    int     n_checked = 0;
    int     n_sent = 0;
    int     send_idle_pct = 0;
    int     recv_idle_pct = 0;
    int     kind_seen[4] = '{0, 0, 0, 0};

    quadratic_root_solver_top dut (.*);

    always #6 aclk = ~aclk;

    function automatic logic [63:0] isqrt(logic [63:0] v);
        logic [63:0] r;
        r = 0;
        for (int i = 31; i >= 0; i--) begin
            logic [63:0] t;
            t = r | (64'd1 << i);
            if (t * t <= v)
                r = t;
        end
        return r;
    endfunction

    function automatic longint div_round(longint n, longint d, inout logic clip);
        logic   neg;
        longint un, ud, q;
        neg = (n < 0) != (d < 0);
        un = n < 0 ? -n : n;
        ud = d < 0 ? -d : d;
        q = (un + ud / 2) / ud;
        if (!neg && q > 64'sd2147483647) begin
            clip = 1;
            return 64'sd2147483647;
        end
        if (neg && q > 64'sd2147483648) begin
            clip = 1;
            return -64'sd2147483648;
        end
        return neg ? -q : q;
    endfunction

    function automatic roots_t solve_quadratic(logic signed [15:0] ca,
                                               logic signed [15:0] cb,
                                               logic signed [15:0] cc);
        roots_t res;
        longint a, b, c, d, nb, s, r1, r2;
        logic   clip;
        a = ca; b = cb; c = cc;
        d = b * b - 4 * a * c;
        nb = -b * 32768;
        r1 = 0; r2 = 0; clip = 0;
        if (a == 0) begin
            res.kind = KIND_A_ZERO;
        end else if (d > 0) begin
            res.kind = KIND_TWO_REAL;
            s = isqrt(d << RAD_SHIFT);
            r1 = div_round(nb + s, a, clip);
            r2 = div_round(nb - s, a, clip);
        end else if (d == 0) begin
            res.kind = KIND_REPEATED;
            r1 = div_round(nb, a, clip);
            r2 = r1;
        end else begin
            res.kind = KIND_COMPLEX;
            s = isqrt((-d) << RAD_SHIFT);
            r1 = div_round(nb, a, clip);
            r2 = div_round(s, a, clip);
        end
        res.r1 = r1[31:0];
        res.r2 = r2[31:0];
        res.disc = d[DISC_W-1:0];
        res.clip = clip;
        return res;
    endfunction

    task automatic send_coefs(logic [15:0] ca, logic [15:0] cb, logic [15:0] cc);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata <= {cc, cb, ca};
        expected_roots = {expected_roots, solve_quadratic(ca, cb, cc)};
        do @(posedge aclk); while (!s_axis_tready);
        n_sent++;
    endtask

    task automatic stop_sending();
        s_axis_tvalid <= 0;
    endtask

    always @(posedge aclk) begin
        if (aresetn)
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            roots_t got, exp_r;
            got.kind = m_axis_tuser;
            got.r1 = m_axis_tdata[31:0];
            got.r2 = m_axis_tdata[63:32];
            got.disc = m_axis_tdata[97:64];
            got.clip = m_axis_tdata[98];
            if (expected_roots.size() == 0) begin
                $display("%0t: unexpected transaction %h", $time, got);
                n_errors++;
            end else begin
                exp_r = expected_roots.pop_front();
                n_checked++;
                kind_seen[exp_r.kind]++;
                if (got.kind !== exp_r.kind) begin
                    $display("%0t: root_kind exp %0d got %0d", $time, exp_r.kind, got.kind);
                    n_errors++;
                end
                if (got.r1 !== exp_r.r1) begin
                    $display("%0t: root_one exp %h got %h", $time, exp_r.r1, got.r1);
                    n_errors++;
                end
                if (got.r2 !== exp_r.r2) begin
                    $display("%0t: root_two exp %h got %h", $time, exp_r.r2, got.r2);
                    n_errors++;
                end
                if (got.disc !== exp_r.disc) begin
                    $display("%0t: disc_value exp %h got %h", $time, exp_r.disc, got.disc);
                    n_errors++;
                end
                if (got.clip !== exp_r.clip) begin
                    $display("%0t: clipped exp %b got %b", $time, exp_r.clip, got.clip);
                    n_errors++;
                end
            end
        end
    end

    function automatic logic [15:0] rand_coef();
        case ($urandom_range(5))
            0: return 16'($urandom_range(0, 15)) - 16'd8;
            1: return $urandom_range(1) ? 16'h7fff - 16'($urandom_range(3))
                                        : 16'h8000 + 16'($urandom_range(3));
            2: return 16'($signed(16'($urandom_range(2047))) - 1024);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic test_directed();
        send_coefs(16'h0100, 16'hfd00, 16'h0200);
        send_coefs(16'h0100, 16'hfe00, 16'h0100);
        send_coefs(16'h0100, 16'h0000, 16'h0100);
        send_coefs(16'h0000, 16'h0300, 16'h0100);
        send_coefs(16'h0000, 16'h8000, 16'h7fff);
        send_coefs(16'h0001, 16'h7fff, 16'h0000);
        send_coefs(16'h0001, 16'h8000, 16'h8000);
        send_coefs(16'hffff, 16'h8000, 16'h7fff);
        send_coefs(16'h7fff, 16'h8000, 16'h8000);
        send_coefs(16'h8000, 16'h8000, 16'h8000);
        send_coefs(16'h8000, 16'h7fff, 16'h7fff);
        send_coefs(16'h7fff, 16'h7fff, 16'h7fff);
        send_coefs(16'h8000, 16'h0000, 16'h7fff);
        send_coefs(16'h0001, 16'h0000, 16'h7fff);
        send_coefs(16'hff00, 16'h0400, 16'hfc00);
        send_coefs(16'h0001, 16'h0002, 16'h0001);
        send_coefs(16'hffff, 16'hffff, 16'hffff);
        send_coefs(16'h0000, 16'h0000, 16'h0000);
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++) begin
            logic [15:0] ca, cb, cc;
            ca = rand_coef();
            cb = rand_coef();
            if ($urandom_range(3) == 0 && ca != 0 && cb[0] == 0) begin
                // b*b == 4ac exactly: pick c = b*b/(4a) where it divides
                longint q;
                q = ($signed(cb) * $signed(cb)) / (4 * $signed(ca));
                cc = (q * 4 * $signed(ca) == $signed(cb) * $signed(cb) &&
                      q >= -32768 && q <= 32767) ? 16'(q) : rand_coef();
            end else begin
                cc = rand_coef();
            end
            send_coefs(ca, cb, cc);
        end
    endtask

    task automatic test_drain_pause();
        stop_sending();
        while (expected_roots.size() != 0)
            @(posedge aclk);
        send_coefs(16'h0200, 16'h0100, 16'hff00);
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        send_idle_pct = 35; recv_idle_pct = 68;
        test_directed();
        test_random(600);
        test_drain_pause();
        send_idle_pct = 68; recv_idle_pct = 35;
        test_random(600);
        send_idle_pct = 0; recv_idle_pct = 0;
        test_random(620);
        stop_sending();
        while (expected_roots.size() != 0)
            @(posedge aclk);
        repeat (80) @(posedge aclk);
        $display("Sent %0d coefficient sets, checked %0d results", n_sent, n_checked);
        $display("Classes: two real %0d, repeated %0d, complex %0d, a zero %0d",
                 kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3]);
        if (n_errors == 0 && expected_roots.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
